### sv/mcat_pkg.sv
package mcat_pkg;

   localparam int CHAN_OUT_BITS = 3;
   localparam int LEVEL_BITS    = 4;
   localparam int THRESH_BITS   = 4;
   localparam int CSR_DATA_BITS = 8;
   localparam int LEVEL_DIVISOR = 75;

   typedef logic [CHAN_OUT_BITS-1:0] chan_out_type;
   typedef logic [LEVEL_BITS-1:0]    level_type;
   typedef logic [THRESH_BITS-1:0]   threshold_type;

   localparam level_type     LEVEL_MAX       = 4'd15;
   localparam threshold_type THRESHOLD_RESET = 4'd15;
   localparam chan_out_type  SHUT_NONE       = 3'd0;

   // lowest bits first: channel_index, level, over_limit, shut_output
   typedef struct packed {
      chan_out_type shut_output;
      logic         over_limit;
      level_type    level;
      chan_out_type channel_index;
   } result_type;

   localparam int RESULT_BITS   = $bits(result_type);
   localparam int RSP_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

### sv/multichannel_current_average_trip_unit.sv
// channel | direction | handshake             | payload
// req     | in        | req_tvalid/req_tready | sample
// rsp     | out       | rsp_tvalid/rsp_tready | channel_index, level, over_limit, shut_output
// csr     | in        | csr_tvalid/csr_tready | trip_threshold
//
// One request per cycle unless rsp_tready low stalls the stages; results pass s1, s2, s3, s4.
// The ring read for a request is issued as it is taken and the ring write happens
// when the request moves on, so the single RAM port pair carries one sample per cycle.
// Reset clears the sums, the channel pointer and the ring counter; ring entries read
// as zero until the first full pass has written them. Stages hold under rsp_tready low
// and empty stages still fill, so requests are taken while a result waits.
module multichannel_current_average_trip_unit #(
   parameter int WINDOW      = 32,
   parameter int CHANNELS    = 6,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,  // sample
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mcat_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // channel_index, level,
                                                             // over_limit, shut_output
   input  logic                                  csr_tvalid,
   output logic                                  csr_tready,
   input  logic [mcat_pkg::CSR_DATA_BITS-1:0]    csr_tdata   // trip_threshold
);

   import mcat_pkg::*;

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);

   threshold_type threshold_ff, threshold_in;

   logic             sum_valid, sum_ready;
   logic [SUM_W-1:0] sum;
   logic [CH_W-1:0]  sum_chan;
   result_type       result;

   assign csr_tready   = 1'b1;
   assign threshold_in = (csr_tvalid && csr_tready) ? csr_tdata[THRESH_BITS-1:0]
                                                     : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   mcat_window #(
      .CHANNELS    (CHANNELS),
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CH_W        (CH_W),
      .SUM_W       (SUM_W)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_sample   (req_tdata[SAMPLE_BITS-1:0]),
      .out_valid   (sum_valid),
      .out_ready   (sum_ready),
      .out_sum     (sum),
      .out_channel (sum_chan)
   );

   mcat_level #(
      .CHANNELS    (CHANNELS),
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CH_W        (CH_W),
      .SUM_W       (SUM_W)
   ) u_level (
      .clock      (clock),
      .reset      (reset),
      .threshold  (threshold_ff),
      .in_valid   (sum_valid),
      .in_ready   (sum_ready),
      .in_sum     (sum),
      .in_channel (sum_chan),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = RSP_DATA_BITS'(result);

endmodule

### sv/mcat_ram.sv
module mcat_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/mcat_window.sv
module mcat_window #(
   parameter int CHANNELS    = 6,
   parameter int WINDOW      = 32,
   parameter int SAMPLE_BITS = 10,
   parameter int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SAMPLE_BITS-1:0] in_sample,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [SUM_W-1:0]       out_sum,
   output logic [CH_W-1:0]        out_channel
);

   localparam int DEPTH  = CHANNELS * WINDOW;
   localparam int ADDR_W = $clog2(DEPTH);

   // ring address walks every channel once per ring position, so it is a plain counter
   logic [CH_W-1:0]   chan_ff, chan_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              first_lap_ff, first_lap_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [CH_W-1:0]        s1_chan_ff;
   logic [ADDR_W-1:0]      s1_addr_ff;
   logic                   s1_fresh_ff;

   logic [SUM_W-1:0] sums_ff [CHANNELS];

   logic             s2_valid_ff, s2_valid_in;
   logic [SUM_W-1:0] s2_sum_ff;
   logic [CH_W-1:0]  s2_chan_ff;

   logic                   s2_ready, accept, advance;
   logic [ADDR_W-1:0]      rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data, old_sample;
   logic [SUM_W-1:0]       new_sum;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign in_ready = !s1_valid_ff || s2_ready;
   assign accept   = in_valid && in_ready;
   assign advance  = s1_valid_ff && s2_ready;
   assign rd_addr  = accept ? addr_ff : s1_addr_ff;

   mcat_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_sample_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign old_sample = s1_fresh_ff ? '0 : rd_data;
   assign new_sum    = sums_ff[s1_chan_ff] - SUM_W'(old_sample) + SUM_W'(s1_sample_ff);

   always_comb begin
      chan_in      = chan_ff;
      addr_in      = addr_ff;
      first_lap_in = first_lap_ff;
      if (accept) begin
         chan_in = (chan_ff == CH_W'(CHANNELS - 1)) ? '0 : chan_ff + 1'b1;
         if (addr_ff == ADDR_W'(DEPTH - 1)) begin
            addr_in      = '0;
            first_lap_in = 1'b0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end
      s1_valid_in = accept || (s1_valid_ff && !s2_ready);
      s2_valid_in = advance || (s2_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff      <= '0;
         addr_ff      <= '0;
         first_lap_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         chan_ff      <= chan_in;
         addr_ff      <= addr_in;
         first_lap_ff <= first_lap_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         if (advance) begin
            sums_ff[s1_chan_ff] <= new_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= in_sample;
         s1_chan_ff   <= chan_ff;
         s1_addr_ff   <= addr_ff;
         s1_fresh_ff  <= first_lap_ff;
      end
      if (advance) begin
         s2_sum_ff  <= new_sum;
         s2_chan_ff <= s1_chan_ff;
      end
   end

   assign out_valid   = s2_valid_ff;
   assign out_sum     = s2_sum_ff;
   assign out_channel = s2_chan_ff;

endmodule

### sv/mcat_level.sv
module mcat_level #(
   parameter int CHANNELS    = 6,
   parameter int WINDOW      = 32,
   parameter int SAMPLE_BITS = 10,
   parameter int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mcat_pkg::threshold_type    threshold,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [SUM_W-1:0]           in_sum,
   input  logic [CH_W-1:0]            in_channel,
   output logic                       out_valid,
   input  logic                       out_ready,
   output mcat_pkg::result_type       out_result
);

   import mcat_pkg::*;

   // floor(sum / (75 * WINDOW)) by reciprocal, exact over the whole sum range
   localparam int DIVISOR = LEVEL_DIVISOR * WINDOW;
   localparam int DIV_W   = $clog2(DIVISOR);
   localparam int SHIFT   = SUM_W + DIV_W;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   logic              s3_valid_ff, s3_valid_in;
   logic [PROD_W-1:0] s3_prod_ff;
   logic [CH_W-1:0]   s3_chan_ff;

   logic       s4_valid_ff, s4_valid_in;
   result_type s4_result_ff;

   logic        s4_ready, load3, load4;
   logic [31:0] quot;
   result_type  result;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign in_ready = !s3_valid_ff || s4_ready;
   assign load3    = in_valid && in_ready;
   assign load4    = s3_valid_ff && s4_ready;

   always_comb begin
      quot                 = 32'(s3_prod_ff[PROD_W-1:SHIFT]);
      result.channel_index = chan_out_type'(s3_chan_ff);
      result.level         = (quot > 32'(LEVEL_MAX)) ? LEVEL_MAX : level_type'(quot);
      result.over_limit    = (result.level > threshold);
      result.shut_output   = SHUT_NONE;
      if (result.over_limit && (s3_chan_ff != '0)) begin
         result.shut_output = chan_out_type'(32'(CHANNELS) - 32'(s3_chan_ff));
      end
      s3_valid_in = load3 || (s3_valid_ff && !s4_ready);
      s4_valid_in = load4 || (s4_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load3) begin
         s3_prod_ff <= PROD_W'(in_sum) * PROD_W'(RECIP);
         s3_chan_ff <= in_channel;
      end
      if (load4) begin
         s4_result_ff <= result;
      end
   end

   assign out_valid  = s4_valid_ff;
   assign out_result = s4_result_ff;

endmodule
